@@ hdl/i2cmw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmw_pkg
// Shared types and constants for the tick-driven I2C master write engine.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

    // default width of the phase delay counter
    localparam int DELAY_WIDTH_DEF = 16;

    // configuration port
    localparam int HALF_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'd1;

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd10;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NACK    = 2'd1;
    localparam logic [1:0] STATUS_REFUSED = 2'd2;

    // bit position of the first data bit (msb first)
    localparam logic [2:0] BIT_MSB = 3'd7;

    // one result beat
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       need_byte;
        logic       byte_taken;
        logic       busy;
        logic       done;
        logic [1:0] status;
    } result_t;

    // configuration seen by the engine
    typedef struct packed {
        logic [HALF_W-1:0] half_period;
        logic              enable;
    } cfg_t;

endpackage

@@ hdl/i2c_master_write_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_write_engine_core
// Tick-driven write-only I2C master: start, address, data bytes, ack, stop.
// Each accepted beat's result is registered, in the skid slot if output stalls.
// Throughput: one input beat per cycle while the skid slot is empty;
// a skid slot lets input continue while one result waits.
// Reset: asynchronous, bus released, idle, half period 10, engine disabled.
// ----------------------------------------------------------------------------
module i2c_master_write_engine_core
    import i2cmw_pkg::*;
#(
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [7:0]           tx_byte,
    input  logic                 last_byte,
    input  logic                 sda_in,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 scl_out,
    output logic                 sda_out,
    output logic                 need_byte,
    output logic                 byte_taken,
    output logic                 busy_res,
    output logic                 done_res,
    output logic [1:0]           status,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t step_result;
    result_t out_data;
    logic    buf_full;
    logic    accept;

    // input beat handshake
    assign in_stall = buf_full;
    assign accept   = in_valid && !in_stall;

    // configuration registers
    i2cmw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // phase sequencer
    i2cmw_fsm #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .tx_byte   (tx_byte),
        .last_byte (last_byte),
        .sda_in    (sda_in),
        .cfg       (cfg),
        .result    (step_result)
    );

    // result register and skid slot
    i2cmw_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // result fields
    assign scl_out    = out_data.scl;
    assign sda_out    = out_data.sda;
    assign need_byte  = out_data.need_byte;
    assign byte_taken = out_data.byte_taken;
    assign busy_res   = out_data.busy;
    assign done_res   = out_data.done;
    assign status     = out_data.status;

endmodule

@@ hdl/i2cmw_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmw_cfg
// Configuration register file: half period and enable.
// ----------------------------------------------------------------------------
module i2cmw_cfg
    import i2cmw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    logic [HALF_W-1:0] half_reg;
    logic              enable_reg;

    // writes are always accepted
    assign cfg_ready = 1'b1;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg   <= HALF_RESET;
            enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: half_reg   <= cfg_data[HALF_W-1:0];
                CFG_ENABLE:      enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign cfg.half_period = half_reg;
    assign cfg.enable      = enable_reg;

endmodule

@@ hdl/i2cmw_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmw_fsm
// Bus phase sequencer: start, eight data bits and ack per byte, stop; one beat per accepted clock.
// ----------------------------------------------------------------------------
module i2cmw_fsm
    import i2cmw_pkg::*;
#(
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       req_type,
    input  logic [7:0] tx_byte,
    input  logic       last_byte,
    input  logic       sda_in,
    input  cfg_t       cfg,
    output result_t    result
);

    localparam int CW = ((DELAY_WIDTH > HALF_W) ? DELAY_WIDTH : HALF_W) + 1;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_SDA_HI,
        PH_ST_SCL_HI,
        PH_ST_SDA_LO,
        PH_ST_SCL_LO,
        PH_BIT_LO,
        PH_BIT_HI,
        PH_POST_LO,
        PH_REL1,
        PH_REL2,
        PH_ACK_HI,
        PH_ACK_LO,
        PH_WAIT,
        PH_SP_SDA_LO,
        PH_SP_SCL_HI,
        PH_SP_SDA_HI
    } phase_t;

    phase_t                 phase_reg,  phase_next;
    logic [2:0]             bit_reg,    bit_next;
    logic [7:0]             shift_reg,  shift_next;
    logic [DELAY_WIDTH-1:0] delay_reg,  delay_next;
    logic                   ending_reg, ending_next;
    logic                   nack_reg,   nack_next;
    logic                   scl_reg,    scl_next;
    logic                   sda_reg,    sda_next;

    logic              parked;
    logic [HALF_W-1:0] half_eff;
    logic              phase_end;
    logic              go;
    phase_t            target;
    logic              taken;
    logic              refused;
    logic              done;

    // idle or waiting for the next byte
    assign parked = (phase_reg == PH_IDLE) || (phase_reg == PH_WAIT);

    // phase length check, zero half period acts as one
    assign half_eff  = (cfg.half_period == '0) ? HALF_W'(1) : cfg.half_period;
    assign phase_end = ((CW'(delay_reg) + CW'(1)) >= CW'(half_eff)) || (&delay_reg);

    // next state for one beat
    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        delay_next  = delay_reg;
        ending_next = ending_reg;
        nack_next   = nack_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        go          = 1'b0;
        target      = PH_IDLE;
        taken       = 1'b0;
        refused     = 1'b0;
        done        = 1'b0;

        if (req_type)
        begin
            // byte offer, only taken when idle or waiting and enabled
            if (parked)
            begin
                if (!cfg.enable)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    taken       = 1'b1;
                    shift_next  = tx_byte;
                    ending_next = last_byte;
                    bit_next    = BIT_MSB;
                    go          = 1'b1;
                    if (phase_reg == PH_IDLE)
                    begin
                        nack_next = 1'b0;
                        target    = PH_ST_SDA_HI;
                    end
                    else
                    begin
                        target = PH_BIT_LO;
                    end
                end
            end
        end
        else if (!parked)
        begin
            // time tick
            if (phase_end)
            begin
                go = 1'b1;
                unique case (phase_reg)
                    PH_ST_SDA_HI: target = PH_ST_SCL_HI;
                    PH_ST_SCL_HI: target = PH_ST_SDA_LO;
                    PH_ST_SDA_LO: target = PH_ST_SCL_LO;
                    PH_ST_SCL_LO:
                    begin
                        bit_next = BIT_MSB;
                        target   = PH_BIT_LO;
                    end
                    PH_BIT_LO:    target = PH_BIT_HI;
                    PH_BIT_HI:
                    begin
                        if (bit_reg == '0)
                        begin
                            target = PH_POST_LO;
                        end
                        else
                        begin
                            bit_next = bit_reg - 3'd1;
                            target   = PH_BIT_LO;
                        end
                    end
                    PH_POST_LO:   target = PH_REL1;
                    PH_REL1:      target = PH_REL2;
                    PH_REL2:      target = PH_ACK_HI;
                    PH_ACK_HI:
                    begin
                        nack_next = sda_in;
                        target    = PH_ACK_LO;
                    end
                    PH_ACK_LO:
                    begin
                        sda_next = 1'b1;
                        target   = (nack_reg || ending_reg) ? PH_SP_SDA_LO : PH_WAIT;
                    end
                    PH_SP_SDA_LO: target = PH_SP_SCL_HI;
                    PH_SP_SCL_HI: target = PH_SP_SDA_HI;
                    PH_SP_SDA_HI:
                    begin
                        done   = 1'b1;
                        target = PH_IDLE;
                    end
                    default:      go = 1'b0;
                endcase
            end
            else
            begin
                delay_next = delay_reg + DELAY_WIDTH'(1);
            end
        end

        // entering a phase restarts the counter and sets the bus levels
        if (go)
        begin
            phase_next = target;
            delay_next = '0;
            unique case (target)
                PH_ST_SDA_HI: sda_next = 1'b1;
                PH_ST_SCL_HI: scl_next = 1'b1;
                PH_ST_SDA_LO: sda_next = 1'b0;
                PH_ST_SCL_LO: scl_next = 1'b0;
                PH_BIT_LO:
                begin
                    scl_next = 1'b0;
                    sda_next = shift_next[bit_next];
                end
                PH_BIT_HI:    scl_next = 1'b1;
                PH_POST_LO:   scl_next = 1'b0;
                PH_REL1:      sda_next = 1'b1;
                PH_ACK_HI:    scl_next = 1'b1;
                PH_ACK_LO:    scl_next = 1'b0;
                PH_SP_SDA_LO: sda_next = 1'b0;
                PH_SP_SCL_HI: scl_next = 1'b1;
                PH_SP_SDA_HI: sda_next = 1'b1;
                default:      ;
            endcase
        end
    end

    // result fields follow the updated state
    always_comb
    begin
        result.scl        = scl_next;
        result.sda        = sda_next;
        result.need_byte  = ((phase_next == PH_IDLE) || (phase_next == PH_WAIT))
                            && cfg.enable;
        result.byte_taken = taken;
        result.busy       = (phase_next != PH_IDLE);
        result.done       = done;
        if (refused)
        begin
            result.status = STATUS_REFUSED;
        end
        else if (nack_next)
        begin
            result.status = STATUS_NACK;
        end
        else
        begin
            result.status = STATUS_OK;
        end
    end

    // state registers, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bit_reg    <= BIT_MSB;
            shift_reg  <= '0;
            delay_reg  <= '0;
            ending_reg <= 1'b0;
            nack_reg   <= 1'b0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            delay_reg  <= delay_next;
            ending_reg <= ending_next;
            nack_reg   <= nack_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
        end
    end

endmodule

@@ hdl/i2cmw_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmw_out_buf
// Result register with a skid slot so input and output stall independently.
// ----------------------------------------------------------------------------
module i2cmw_out_buf
    import i2cmw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    out_free;

    // output slot can take a beat this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (load)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (load)
        begin
            if (out_free)
            begin
                out_reg <= load_data;
            end
            else
            begin
                skid_reg <= load_data;
            end
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
